@@ rtl/core/ntpssp_pkg.sv @@
// Shared types and constants of the NTP read-status poller.
package ntpssp_pkg;

   localparam int MAX_DATA_DEFAULT    = 468;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int HDR_LEN             = 12;
   localparam int REQ_LEN             = 12;

   localparam logic [15:0] SEQ_ON_CONNECT = 16'd42;
   localparam logic [15:0] SEQ_RESET      = 16'd1;
   localparam logic [7:0]  REQ_BYTE0      = 8'h1E;
   localparam logic [7:0]  REQ_BYTE1      = 8'h01;

   localparam logic [2:0] HDR_VERSION     = 3'd3;
   localparam logic [2:0] HDR_MODE        = 3'd6;
   localparam logic [4:0] HDR_OPCODE      = 5'd1;
   localparam logic [1:0] LEAP_ALARM      = 2'd3;
   localparam logic [5:0] SRC_UDP         = 6'd6;
   localparam logic [2:0] SEL_CANDIDATE   = 3'd5;
   localparam logic [2:0] SEL_SYSPEER     = 3'd6;

   localparam logic CMD_POLL  = 1'b0;
   localparam logic CMD_REPLY = 1'b1;

   localparam logic KIND_REQ     = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [3:0] {
      VERD_SYNCED  = 4'd0,
      VERD_NO_PEER = 4'd1,
      VERD_SHORT   = 4'd2,
      VERD_VERSION = 4'd3,
      VERD_MODE    = 4'd4,
      VERD_OPCODE  = 4'd5,
      VERD_NOTRESP = 4'd6,
      VERD_ERRFLAG = 4'd7,
      VERD_SEQ     = 4'd8,
      VERD_LEAP    = 4'd9,
      VERD_COUNT   = 4'd10,
      VERD_SIZE    = 4'd11
   } verdict_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] seq;
      verdict_type verdict;
      logic        synced;
      logic        odd;
   } job_type;

endpackage

@@ rtl/core/ntpssp_front.sv @@
// Front end: accepts commands and reply bytes, captures the header, judges replies.
module ntpssp_front #(
   parameter int MAX_DATA = ntpssp_pkg::MAX_DATA_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                q_full,
   input  logic                cmd,
   input  logic [7:0]          rx_byte,
   input  logic                rx_last,
   output logic                job_push,
   output ntpssp_pkg::job_type job
);

   localparam logic [9:0] DataEnd = 10'(ntpssp_pkg::HDR_LEN + MAX_DATA);
   localparam logic [8:0] HdrLen  = 9'(ntpssp_pkg::HDR_LEN);
   localparam logic [8:0] ShortLim = 9'(ntpssp_pkg::HDR_LEN - 1);
   localparam logic [16:0] MaxData = 17'(MAX_DATA);

   logic [15:0] seq_ff, seq_in;
   logic        link_ff, link_in;
   logic [8:0]  idx_ff, idx_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [15:0] rseq_ff, rseq_in;
   logic [15:0] stat_ff, stat_in;
   logic [15:0] off_ff, off_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        good_ff, good_in;
   logic        sync_ff, sync_in;

   logic        accept;
   logic        reply;
   logic [8:0]  d;
   logic        peer_good;
   logic [16:0] size_sum;
   ntpssp_pkg::verdict_type verd;
   logic        odd;
   logic [15:0] seq_base;

   assign accept = in_valid && !q_full;
   assign reply  = accept && (cmd == ntpssp_pkg::CMD_REPLY) && link_ff;
   assign d      = idx_ff - HdrLen;
   assign size_sum = {1'b0, off_in} + {1'b0, cnt_in};
   assign seq_base = link_ff ? seq_ff : ntpssp_pkg::SEQ_ON_CONNECT;

   assign peer_good = rx_byte[7] && rx_byte[4] &&
                      ((rx_byte[2:0] == ntpssp_pkg::SEL_CANDIDATE) ||
                       (rx_byte[2:0] == ntpssp_pkg::SEL_SYSPEER));

   // capture and peer scan
   always_comb begin
      hdr_in  = hdr_ff;
      rseq_in = rseq_ff;
      stat_in = stat_ff;
      off_in  = off_ff;
      cnt_in  = cnt_ff;
      good_in = good_ff;
      if (reply) begin
         if (idx_ff < HdrLen) begin
            case (idx_ff[3:1])
               3'd0: if (!idx_ff[0]) hdr_in[15:8] = rx_byte; else hdr_in[7:0] = rx_byte;
               3'd1: if (!idx_ff[0]) rseq_in[15:8] = rx_byte; else rseq_in[7:0] = rx_byte;
               3'd2: if (!idx_ff[0]) stat_in[15:8] = rx_byte; else stat_in[7:0] = rx_byte;
               3'd4: if (!idx_ff[0]) off_in[15:8] = rx_byte; else off_in[7:0] = rx_byte;
               3'd5: if (!idx_ff[0]) cnt_in[15:8] = rx_byte; else cnt_in[7:0] = rx_byte;
               default: ;
            endcase
         end else if ({1'b0, idx_ff} < DataEnd) begin
            if ((idx_ff[1:0] == 2'd2) && ({7'd0, d[8:2], 2'b00} < cnt_ff) && peer_good) begin
               good_in = 1'b1;
            end
         end
      end
   end

   // verdict in check order
   always_comb begin
      odd = 1'b0;
      if (idx_ff < ShortLim) begin
         verd = ntpssp_pkg::VERD_SHORT;
      end else if (hdr_in[13:11] != ntpssp_pkg::HDR_VERSION) begin
         verd = ntpssp_pkg::VERD_VERSION;
      end else if (hdr_in[10:8] != ntpssp_pkg::HDR_MODE) begin
         verd = ntpssp_pkg::VERD_MODE;
      end else if (hdr_in[4:0] != ntpssp_pkg::HDR_OPCODE) begin
         verd = ntpssp_pkg::VERD_OPCODE;
      end else if (!hdr_in[7]) begin
         verd = ntpssp_pkg::VERD_NOTRESP;
      end else if (hdr_in[6]) begin
         verd = ntpssp_pkg::VERD_ERRFLAG;
      end else if (rseq_in != seq_ff) begin
         verd = ntpssp_pkg::VERD_SEQ;
      end else if (stat_in[15:14] == ntpssp_pkg::LEAP_ALARM) begin
         verd = ntpssp_pkg::VERD_LEAP;
      end else begin
         odd = (stat_in[13:8] != ntpssp_pkg::SRC_UDP);
         if (cnt_in[1:0] != 2'd0) begin
            verd = ntpssp_pkg::VERD_COUNT;
         end else if (size_sum > MaxData) begin
            verd = ntpssp_pkg::VERD_SIZE;
         end else if (good_in) begin
            verd = ntpssp_pkg::VERD_SYNCED;
         end else begin
            verd = ntpssp_pkg::VERD_NO_PEER;
         end
      end
   end

   // state update and job generation
   always_comb begin
      seq_in   = seq_ff;
      link_in  = link_ff;
      idx_in   = idx_ff;
      sync_in  = sync_ff;
      job_push = 1'b0;
      job      = '{kind: ntpssp_pkg::KIND_REQ, seq: seq_ff,
                   verdict: ntpssp_pkg::VERD_SYNCED, synced: 1'b0, odd: 1'b0};
      if (accept && (cmd == ntpssp_pkg::CMD_POLL)) begin
         seq_in   = seq_base + 16'd1;
         link_in  = 1'b1;
         idx_in   = '0;
         job_push = 1'b1;
         job.seq  = seq_in;
      end else if (reply) begin
         if (idx_ff != 9'h1FF) begin
            idx_in = idx_ff + 9'd1;
         end
         if (rx_last) begin
            idx_in = '0;
            if (verd == ntpssp_pkg::VERD_SHORT) begin
               link_in = 1'b0;
            end
            if ((verd == ntpssp_pkg::VERD_SYNCED) || (verd == ntpssp_pkg::VERD_NO_PEER)) begin
               sync_in = good_in;
            end
            job_push    = 1'b1;
            job.kind    = ntpssp_pkg::KIND_VERDICT;
            job.verdict = verd;
            job.synced  = sync_in;
            job.odd     = odd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= ntpssp_pkg::SEQ_RESET;
         link_ff <= 1'b0;
         idx_ff  <= '0;
         hdr_ff  <= '0;
         rseq_ff <= '0;
         stat_ff <= '0;
         off_ff  <= '0;
         cnt_ff  <= '0;
         good_ff <= 1'b0;
         sync_ff <= 1'b0;
      end else begin
         seq_ff  <= seq_in;
         link_ff <= link_in;
         idx_ff  <= idx_in;
         hdr_ff  <= hdr_in;
         rseq_ff <= rseq_in;
         stat_ff <= stat_in;
         off_ff  <= off_in;
         cnt_ff  <= cnt_in;
         if (accept && ((cmd == ntpssp_pkg::CMD_POLL) || (reply && rx_last))) begin
            good_ff <= 1'b0;
         end else begin
            good_ff <= good_in;
         end
         sync_ff <= sync_in;
      end
   end

endmodule

@@ rtl/core/ntpssp_queue.sv @@
// Job queue between the front end and the result sequencer.
module ntpssp_queue #(
   parameter int DEPTH = ntpssp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ntpssp_pkg::job_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                nonempty,
   output ntpssp_pkg::job_type head
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] Depth = CntW'(DEPTH);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

   ntpssp_pkg::job_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push;
   logic            do_pop;

   assign full     = (cnt_ff == Depth);
   assign nonempty = (cnt_ff != '0);
   assign head     = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/core/ntpssp_back.sv @@
// Back end: expands queued jobs into request bytes or a verdict, with an output register.
module ntpssp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_nonempty,
   input  ntpssp_pkg::job_type q_head,
   output logic                q_pop,
   input  logic                out_pop,
   output logic                out_empty,
   output logic                kind,
   output logic [7:0]          tx_byte,
   output logic                tx_last,
   output logic [3:0]          verdict,
   output logic                synced,
   output logic                odd_source
);

   localparam logic [3:0] LastReq = 4'(ntpssp_pkg::REQ_LEN - 1);

   ntpssp_pkg::job_type job_ff, job_in;
   logic        job_valid_ff, job_valid_in;
   logic [3:0]  pos_ff, pos_in;
   logic        out_valid_ff, out_valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [3:0]  verd_ff, verd_in;
   logic        sync_ff, sync_in;
   logic        odd_ff, odd_in;
   logic        out_free;
   logic        emit;
   logic        job_done;

   assign out_free = !out_valid_ff || out_pop;
   assign emit     = out_free && job_valid_ff;
   assign job_done = (job_ff.kind == ntpssp_pkg::KIND_VERDICT) || (pos_ff == LastReq);
   assign q_pop    = q_nonempty && (!job_valid_ff || (emit && job_done));

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !out_pop;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      verd_in      = verd_ff;
      sync_in      = sync_ff;
      odd_in       = odd_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         kind_in      = job_ff.kind;
         if (job_ff.kind == ntpssp_pkg::KIND_VERDICT) begin
            byte_in = 8'd0;
            last_in = 1'b1;
            verd_in = job_ff.verdict;
            sync_in = job_ff.synced;
            odd_in  = job_ff.odd;
         end else begin
            case (pos_ff)
               4'd0:    byte_in = ntpssp_pkg::REQ_BYTE0;
               4'd1:    byte_in = ntpssp_pkg::REQ_BYTE1;
               4'd2:    byte_in = job_ff.seq[15:8];
               4'd3:    byte_in = job_ff.seq[7:0];
               default: byte_in = 8'd0;
            endcase
            last_in = (pos_ff == LastReq);
            verd_in = ntpssp_pkg::VERD_SYNCED;
            sync_in = 1'b0;
            odd_in  = 1'b0;
         end
         pos_in = pos_ff + 4'd1;
         if (job_done) begin
            job_valid_in = 1'b0;
         end
      end
      if (q_pop) begin
         job_in       = q_head;
         job_valid_in = 1'b1;
         pos_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
      job_ff  <= job_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      verd_ff <= verd_in;
      sync_ff <= sync_in;
      odd_ff  <= odd_in;
   end

   assign out_empty  = !out_valid_ff;
   assign kind       = kind_ff;
   assign tx_byte    = byte_ff;
   assign tx_last    = last_ff;
   assign verdict    = verd_ff;
   assign synced     = sync_ff;
   assign odd_source = odd_ff;

endmodule

@@ rtl/core/ntp_sync_status_poller_unit.sv @@
// Top level of the NTP read-status poller: front end, job queue and result sequencer.
// Results pass the job queue, the back-end job register and the output register.
// One input item per cycle unless full; a poll yields 12 request bytes at one per cycle,
// a final reply byte after a poll one verdict; one result per cycle leaves on rsp_pop.
// full rises while the job queue holds QUEUE_DEPTH jobs not yet taken by the back end.
// Reset (synchronous, active high) empties the queue and output register; sequence is 1.
module ntp_sync_status_poller_unit #(
   parameter int MAX_DATA    = ntpssp_pkg::MAX_DATA_DEFAULT,
   parameter int QUEUE_DEPTH = ntpssp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_cmd,
   input  logic [7:0] req_rx_byte,
   input  logic       req_rx_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_kind,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last,
   output logic [3:0] rsp_verdict,
   output logic       rsp_synced,
   output logic       rsp_odd_source
);

   logic                job_push;
   ntpssp_pkg::job_type job;
   logic                q_pop;
   logic                q_nonempty;
   ntpssp_pkg::job_type q_head;

   ntpssp_front #(
      .MAX_DATA(MAX_DATA)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_push),
      .q_full   (req_full),
      .cmd      (req_cmd),
      .rx_byte  (req_rx_byte),
      .rx_last  (req_rx_last),
      .job_push (job_push),
      .job      (job)
   );

   ntpssp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job),
      .full      (req_full),
      .pop       (q_pop),
      .nonempty  (q_nonempty),
      .head      (q_head)
   );

   ntpssp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .out_pop    (rsp_pop),
      .out_empty  (rsp_empty),
      .kind       (rsp_kind),
      .tx_byte    (rsp_tx_byte),
      .tx_last    (rsp_tx_last),
      .verdict    (rsp_verdict),
      .synced     (rsp_synced),
      .odd_source (rsp_odd_source)
   );

endmodule
